[hdl/vector_path_command_resolver_macros.svh]
// ----------------------------------------------------------------------------
// vector path command resolver assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef VECTOR_PATH_COMMAND_RESOLVER_MACROS_SVH
`define VECTOR_PATH_COMMAND_RESOLVER_MACROS_SVH

// same-cycle implication, held off during reset
`define VPCR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, held off during reset
`define VPCR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/vpcr_pkg.sv]
// ----------------------------------------------------------------------------
// vpcr_pkg
// types, codes and saturating helpers of the vector path command resolver
// ----------------------------------------------------------------------------
package vpcr_pkg;

	localparam int COORD_W = 32;
	localparam int NUM_ARGS = 6;
	localparam int TUSER_W = 8;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [NUM_ARGS-1:0][COORD_W-1:0] args_t;

	typedef enum logic [3:0] {
		MODE_MOVE   = 4'd0,
		MODE_LINE   = 4'd1,
		MODE_HORIZ  = 4'd2,
		MODE_VERT   = 4'd3,
		MODE_CUBIC  = 4'd4,
		MODE_SMOOTH = 4'd5,
		MODE_QUAD   = 4'd6,
		MODE_CLOSE  = 4'd7,
		MODE_ARC    = 4'd8
	} mode_t;

	typedef enum logic [2:0] {
		KIND_MOVE  = 3'd0,
		KIND_LINE  = 3'd1,
		KIND_CUBIC = 3'd2,
		KIND_QUAD  = 3'd3,
		KIND_CLOSE = 3'd4
	} kind_t;

	typedef struct packed {
		coord_t cur_x;
		coord_t cur_y;
		coord_t last_ctrl_x;
		coord_t last_ctrl_y;
		logic   last_was_cubic;
		coord_t start_x;
		coord_t start_y;
	} path_state_t;

	typedef struct packed {
		kind_t  segment_kind;
		coord_t end_x;
		coord_t end_y;
		coord_t ctrl1_x;
		coord_t ctrl1_y;
		coord_t ctrl2_x;
		coord_t ctrl2_y;
		logic   saturated;
	} segment_t;

	typedef struct packed {
		logic   sat;
		coord_t val;
	} sat_coord_t;

	localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	// absolute coordinate, clamped sum with the base when relative
	function automatic sat_coord_t sat_resolve(coord_t arg, coord_t base, logic rel);
		logic signed [COORD_W:0] sum;
		sat_coord_t r;
		sum = {arg[COORD_W-1], arg} + {base[COORD_W-1], base};
		r.sat = 1'b0;
		r.val = arg;
		if (rel) begin
			if (sum[COORD_W] != sum[COORD_W-1]) begin
				r.sat = 1'b1;
				r.val = sum[COORD_W] ? COORD_MIN : COORD_MAX;
			end else begin
				r.val = sum[COORD_W-1:0];
			end
		end
		return r;
	endfunction

	// reflection of last about cur, clamped
	function automatic sat_coord_t sat_reflect(coord_t cur, coord_t last);
		logic signed [COORD_W+1:0] d;
		sat_coord_t r;
		d = {cur[COORD_W-1], cur, 1'b0} - {{2{last[COORD_W-1]}}, last};
		r.sat = !((d[COORD_W+1:COORD_W-1] == 3'b000) || (d[COORD_W+1:COORD_W-1] == 3'b111));
		if (r.sat) begin
			r.val = d[COORD_W+1] ? COORD_MIN : COORD_MAX;
		end else begin
			r.val = d[COORD_W-1:0];
		end
		return r;
	endfunction

endpackage

[hdl/vector_path_command_resolver.sv]
// ----------------------------------------------------------------------------
// vector_path_command_resolver
// turns tokenized path commands into absolute path segments
// ----------------------------------------------------------------------------
// Accepts one command per clock cycle while the output is not stalled. Each
// command is resolved combinationally from the input register against the
// current point, subpath start and last control point; its absolute segment
// is offered from the output register until taken. The path state is updated
// as the segment is registered, so the next command can follow directly. Arcs
// and unknown kinds yield no segment. While a segment waits at the output, one
// more command is taken into the input register.
module vector_path_command_resolver import vpcr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [191:0]         s_axis_tdata,  // arg0, arg1, arg2, arg3, arg4, arg5
	input  logic [TUSER_W-1:0]   s_axis_tuser,  // mode[3:0], relative, zero pad
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [191:0]         m_axis_tdata,  // end_x, end_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y
	output logic [TUSER_W-1:0]   m_axis_tuser   // segment_kind[2:0], saturated, zero pad
);

	logic        valid_s1;
	mode_t       mode_s1;
	logic        relative_s1;
	args_t       args_s1;
	logic        valid_s2;
	segment_t    segment_s2;
	path_state_t state_q;
	path_state_t next_state;
	segment_t    segment;
	logic        emit;
	logic        advance;

	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			mode_s1     <= mode_t'(s_axis_tuser[3:0]);
			relative_s1 <= s_axis_tuser[4];
			args_s1     <= s_axis_tdata;
		end
	end

	vpcr_resolve u_resolve (
		.mode       (mode_s1),
		.relative   (relative_s1),
		.args       (args_s1),
		.state      (state_q),
		.next_state (next_state),
		.segment    (segment),
		.emit       (emit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= '0;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			state_q  <= next_state;
			valid_s2 <= emit;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			segment_s2 <= segment;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {segment_s2.ctrl2_y, segment_s2.ctrl2_x, segment_s2.ctrl1_y,
		segment_s2.ctrl1_x, segment_s2.end_y, segment_s2.end_x};
	assign m_axis_tuser  = {4'b0000, segment_s2.saturated, segment_s2.segment_kind};

endmodule

[hdl/vpcr_resolve.sv]
// ----------------------------------------------------------------------------
// vpcr_resolve
// decodes one command against the path state into a segment and next state
// ----------------------------------------------------------------------------
module vpcr_resolve import vpcr_pkg::*; (
	input  mode_t       mode,
	input  logic        relative,
	input  args_t       args,
	input  path_state_t state,
	output path_state_t next_state,
	output segment_t    segment,
	output logic        emit
);

	sat_coord_t rx0, ry0, ry1, rx2, ry3, rx4, ry5, refl_x, refl_y;
	logic       cubic;

	assign rx0    = sat_resolve(coord_t'(args[0]), state.cur_x, relative);
	assign ry0    = sat_resolve(coord_t'(args[0]), state.cur_y, relative);
	assign ry1    = sat_resolve(coord_t'(args[1]), state.cur_y, relative);
	assign rx2    = sat_resolve(coord_t'(args[2]), state.cur_x, relative);
	assign ry3    = sat_resolve(coord_t'(args[3]), state.cur_y, relative);
	assign rx4    = sat_resolve(coord_t'(args[4]), state.cur_x, relative);
	assign ry5    = sat_resolve(coord_t'(args[5]), state.cur_y, relative);
	assign refl_x = sat_reflect(state.cur_x, state.last_ctrl_x);
	assign refl_y = sat_reflect(state.cur_y, state.last_ctrl_y);

	always_comb begin
		next_state = state;
		segment    = '0;
		emit       = 1'b1;
		cubic      = 1'b0;
		case (mode)
			MODE_MOVE, MODE_LINE: begin
				segment.segment_kind = (mode == MODE_MOVE) ? KIND_MOVE : KIND_LINE;
				segment.end_x        = rx0.val;
				segment.end_y        = ry1.val;
				segment.saturated    = rx0.sat | ry1.sat;
			end
			MODE_HORIZ: begin
				segment.segment_kind = KIND_LINE;
				segment.end_x        = rx0.val;
				segment.end_y        = state.cur_y;
				segment.saturated    = rx0.sat;
			end
			MODE_VERT: begin
				segment.segment_kind = KIND_LINE;
				segment.end_x        = state.cur_x;
				segment.end_y        = ry0.val;
				segment.saturated    = ry0.sat;
			end
			MODE_CUBIC: begin
				segment.segment_kind = KIND_CUBIC;
				segment.ctrl1_x      = rx0.val;
				segment.ctrl1_y      = ry1.val;
				segment.ctrl2_x      = rx2.val;
				segment.ctrl2_y      = ry3.val;
				segment.end_x        = rx4.val;
				segment.end_y        = ry5.val;
				segment.saturated    = rx0.sat | ry1.sat | rx2.sat | ry3.sat | rx4.sat | ry5.sat;
				cubic                = 1'b1;
			end
			MODE_SMOOTH: begin
				segment.segment_kind = KIND_CUBIC;
				if (state.last_was_cubic) begin
					segment.ctrl1_x = refl_x.val;
					segment.ctrl1_y = refl_y.val;
				end else begin
					segment.ctrl1_x = state.cur_x;
					segment.ctrl1_y = state.cur_y;
				end
				segment.ctrl2_x   = rx0.val;
				segment.ctrl2_y   = ry1.val;
				segment.end_x     = rx2.val;
				segment.end_y     = ry3.val;
				segment.saturated = (state.last_was_cubic & (refl_x.sat | refl_y.sat))
					| rx0.sat | ry1.sat | rx2.sat | ry3.sat;
				cubic             = 1'b1;
			end
			MODE_QUAD: begin
				segment.segment_kind = KIND_QUAD;
				segment.ctrl1_x      = rx0.val;
				segment.ctrl1_y      = ry1.val;
				segment.end_x        = rx2.val;
				segment.end_y        = ry3.val;
				segment.saturated    = rx0.sat | ry1.sat | rx2.sat | ry3.sat;
			end
			MODE_CLOSE: begin
				segment.segment_kind = KIND_CLOSE;
				segment.end_x        = state.start_x;
				segment.end_y        = state.start_y;
			end
			MODE_ARC: begin
				emit                      = 1'b0;
				next_state.last_was_cubic = 1'b0;
			end
			default: begin
				emit = 1'b0;
			end
		endcase

		if (emit) begin
			next_state.cur_x          = segment.end_x;
			next_state.cur_y          = segment.end_y;
			next_state.last_was_cubic = cubic;
			if (cubic) begin
				next_state.last_ctrl_x = segment.ctrl2_x;
				next_state.last_ctrl_y = segment.ctrl2_y;
			end
			if (mode == MODE_MOVE) begin
				next_state.start_x = segment.end_x;
				next_state.start_y = segment.end_y;
			end
		end
	end

endmodule

[hdl/vpcr_checker.sv]
// ----------------------------------------------------------------------------
// vpcr_checker
// port-level checks of the vector path command resolver, bound to the top
// ----------------------------------------------------------------------------
`include "vector_path_command_resolver_macros.svh"

module vpcr_checker import vpcr_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               s_axis_tready,
	input logic               m_axis_tvalid,
	input logic               m_axis_tready,
	input logic [191:0]       m_axis_tdata,
	input logic [TUSER_W-1:0] m_axis_tuser
);

	// stalled result holds
	`VPCR_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
		"stalled result changed")

	// an empty output stage never blocks the input
	`VPCR_ASSERT_NOW(a_ready_when_empty, clk, arst_n, !m_axis_tvalid, s_axis_tready,
		"input blocked with empty output")

	// move, line and close carry no control points
	`VPCR_ASSERT_NOW(a_no_ctrl, clk, arst_n,
		m_axis_tvalid && (m_axis_tuser[2:0] == KIND_MOVE || m_axis_tuser[2:0] == KIND_LINE
		|| m_axis_tuser[2:0] == KIND_CLOSE),
		m_axis_tdata[191:64] == '0, "control point on a segment without one")

	// quadratic has no second control point
	`VPCR_ASSERT_NOW(a_quad_ctrl2, clk, arst_n, m_axis_tvalid && m_axis_tuser[2:0] == KIND_QUAD,
		m_axis_tdata[191:128] == '0, "second control point on a quadratic")

	// close never saturates
	`VPCR_ASSERT_NOW(a_close_sat, clk, arst_n, m_axis_tvalid && m_axis_tuser[2:0] == KIND_CLOSE,
		!m_axis_tuser[3], "saturation flag on close")

endmodule

bind vector_path_command_resolver vpcr_checker u_vpcr_checker (.*);

[tb/sv/vector_path_command_resolver_test.sv]
// ----------------------------------------------------------------------------
// vector_path_command_resolver_test
// self-checking bench for the vector path command resolver
// ----------------------------------------------------------------------------
// Drives tokenized path commands on the slave stream and checks each absolute
// segment on the master stream against a predictor that tracks the current
// point, subpath start and last cubic control point. A short directed run
// covers extreme coordinates, every mode, saturation, smooth-cubic reflection
// and ignored kinds. Random paths follow in three phases with different idle
// and stall rates, one long output hold-off and a drain between phases.
module vector_path_command_resolver_test;
	timeunit 1ns;
	timeprecision 1ps;
	import vpcr_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES = 120;

	class path_scoreboard;
		coord_t cur_x, cur_y, last_ctrl_x, last_ctrl_y, start_x, start_y;
		bit last_was_cubic;
		bit clamped;
		segment_t segment_q[$];
		int errors;

		function new();
			cur_x = 0;
			cur_y = 0;
			last_ctrl_x = 0;
			last_ctrl_y = 0;
			start_x = 0;
			start_y = 0;
			last_was_cubic = 0;
			errors = 0;
		endfunction

		function coord_t clamp_sum(longint v);
			if (v > longint'(COORD_MAX)) begin
				clamped = 1;
				return COORD_MAX;
			end
			if (v < longint'(COORD_MIN)) begin
				clamped = 1;
				return COORD_MIN;
			end
			return coord_t'(v);
		endfunction

		function coord_t place(coord_t arg, coord_t base, bit rel);
			if (!rel)
				return arg;
			return clamp_sum(longint'(base) + longint'(arg));
		endfunction

		// predicts the segment of one accepted command
		function void note_command(logic [3:0] mode, logic rel, args_t args);
			segment_t seg;
			bit cubic;
			seg = '0;
			cubic = 0;
			clamped = 0;
			case (mode)
				MODE_MOVE, MODE_LINE: begin
					seg.end_x = place(args[0], cur_x, rel);
					seg.end_y = place(args[1], cur_y, rel);
					seg.segment_kind = (mode == MODE_MOVE) ? KIND_MOVE : KIND_LINE;
				end
				MODE_HORIZ: begin
					seg.end_x = place(args[0], cur_x, rel);
					seg.end_y = cur_y;
					seg.segment_kind = KIND_LINE;
				end
				MODE_VERT: begin
					seg.end_x = cur_x;
					seg.end_y = place(args[0], cur_y, rel);
					seg.segment_kind = KIND_LINE;
				end
				MODE_CUBIC: begin
					seg.ctrl1_x = place(args[0], cur_x, rel);
					seg.ctrl1_y = place(args[1], cur_y, rel);
					seg.ctrl2_x = place(args[2], cur_x, rel);
					seg.ctrl2_y = place(args[3], cur_y, rel);
					seg.end_x = place(args[4], cur_x, rel);
					seg.end_y = place(args[5], cur_y, rel);
					seg.segment_kind = KIND_CUBIC;
					cubic = 1;
				end
				MODE_SMOOTH: begin
					if (last_was_cubic) begin
						seg.ctrl1_x = clamp_sum(2 * longint'(cur_x) - longint'(last_ctrl_x));
						seg.ctrl1_y = clamp_sum(2 * longint'(cur_y) - longint'(last_ctrl_y));
					end else begin
						seg.ctrl1_x = cur_x;
						seg.ctrl1_y = cur_y;
					end
					seg.ctrl2_x = place(args[0], cur_x, rel);
					seg.ctrl2_y = place(args[1], cur_y, rel);
					seg.end_x = place(args[2], cur_x, rel);
					seg.end_y = place(args[3], cur_y, rel);
					seg.segment_kind = KIND_CUBIC;
					cubic = 1;
				end
				MODE_QUAD: begin
					seg.ctrl1_x = place(args[0], cur_x, rel);
					seg.ctrl1_y = place(args[1], cur_y, rel);
					seg.end_x = place(args[2], cur_x, rel);
					seg.end_y = place(args[3], cur_y, rel);
					seg.segment_kind = KIND_QUAD;
				end
				MODE_CLOSE: begin
					seg.end_x = start_x;
					seg.end_y = start_y;
					seg.segment_kind = KIND_CLOSE;
				end
				MODE_ARC: begin
					last_was_cubic = 0;
					return;
				end
				default: return;
			endcase
			seg.saturated = clamped;
			cur_x = seg.end_x;
			cur_y = seg.end_y;
			if (mode == MODE_MOVE) begin
				start_x = seg.end_x;
				start_y = seg.end_y;
			end
			last_was_cubic = cubic;
			if (cubic) begin
				last_ctrl_x = seg.ctrl2_x;
				last_ctrl_y = seg.ctrl2_y;
			end
			segment_q.push_back(seg);
		endfunction

		function void check_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				errors++;
				$error("%s: expected %h, got %h", name, want, got);
			end
		endfunction

		// compares one accepted segment with the oldest prediction
		function void check_segment(logic [191:0] data, logic [TUSER_W-1:0] user);
			segment_t want;
			if (segment_q.size() == 0) begin
				errors++;
				$error("segment with none predicted: kind %h end %h %h",
					user[2:0], data[31:0], data[63:32]);
				return;
			end
			want = segment_q[0];
			segment_q.delete(0);
			check_field("segment_kind", 32'(want.segment_kind), 32'(user[2:0]));
			check_field("end_x", want.end_x, data[0 +: 32]);
			check_field("end_y", want.end_y, data[32 +: 32]);
			check_field("ctrl1_x", want.ctrl1_x, data[64 +: 32]);
			check_field("ctrl1_y", want.ctrl1_y, data[96 +: 32]);
			check_field("ctrl2_x", want.ctrl2_x, data[128 +: 32]);
			check_field("ctrl2_y", want.ctrl2_y, data[160 +: 32]);
			check_field("saturated", 32'(want.saturated), 32'(user[3]));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [191:0] s_axis_tdata = '0;       // arg0, arg1, arg2, arg3, arg4, arg5
	logic [TUSER_W-1:0] s_axis_tuser = '0; // mode[3:0], relative, zero pad
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [191:0] m_axis_tdata;            // end_x, end_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y
	logic [TUSER_W-1:0] m_axis_tuser;      // segment_kind[2:0], saturated, zero pad

	path_scoreboard sb = new();
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	int hold_left = 0;
	int commands_sent = 0;
	int quiet_cycles = 0;

	vector_path_command_resolver dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				sb.check_segment(m_axis_tdata, m_axis_tuser);
			if (s_axis_tvalid && s_axis_tready)
				sb.note_command(s_axis_tuser[3:0], s_axis_tuser[4], s_axis_tdata);
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[vector_path_command_resolver] ERROR");
			$finish;
		end
	end

	function automatic args_t operands(coord_t a0, coord_t a1 = 0, coord_t a2 = 0,
			coord_t a3 = 0, coord_t a4 = 0, coord_t a5 = 0);
		args_t a;
		a[0] = a0;
		a[1] = a1;
		a[2] = a2;
		a[3] = a3;
		a[4] = a4;
		a[5] = a5;
		return a;
	endfunction

	function automatic coord_t random_coord();
		case ($urandom_range(11))
			0: return COORD_MAX;
			1: return COORD_MIN;
			2: return COORD_MAX - $urandom_range(65535);
			3: return COORD_MIN + $urandom_range(65535);
			4, 5: return $urandom;
			default: return $urandom_range(32'h0020_0000) - 32'h0010_0000;
		endcase
	endfunction

	function automatic args_t random_operands();
		args_t a;
		for (int i = 0; i < NUM_ARGS; i++)
			a[i] = random_coord();
		return a;
	endfunction

	function automatic logic random_rel();
		return 1'($urandom_range(1));
	endfunction

	task automatic send_command(logic [3:0] mode, logic rel, args_t args);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= args;
		s_axis_tuser <= {3'b000, rel, mode};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		if (mode <= MODE_ARC)
			commands_sent++;
	endtask

	task automatic drain_segments();
		s_axis_tvalid <= 1'b0;
		while (sb.segment_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic directed_paths();
		coord_t ones;
		ones = '1;
		send_command(MODE_LINE, 1'b0, operands(COORD_MAX, COORD_MIN));
		send_command(MODE_LINE, 1'b1, operands(32'sd1, ones));
		send_command(MODE_MOVE, 1'b0, operands(32'sh0001_0000, 32'sh0002_0000));
		send_command(MODE_HORIZ, 1'b1, operands(32'sh0005_0000));
		send_command(MODE_VERT, 1'b0, operands(COORD_MIN));
		send_command(MODE_CUBIC, 1'b1, operands(32'sh0001_0000, 32'sh0001_0000,
			32'sh0002_0000, 32'shFFFF_0000, 32'sh0003_0000, 32'sh0004_0000));
		send_command(MODE_SMOOTH, 1'b0, operands(32'sh0007_0000, 32'sh0008_0000,
			32'sh0009_0000, 32'sh000A_0000));
		send_command(MODE_SMOOTH, 1'b1, operands(32'shFFFE_8000, 32'sh0000_4000,
			32'sh0001_0000, 32'shFFFF_0000));
		send_command(MODE_QUAD, 1'b0, operands(32'sh0003_0000, 32'sh0004_0000,
			32'sh0005_0000, 32'sh0006_0000));
		// smooth after a quadratic takes the current point
		send_command(MODE_SMOOTH, 1'b0, operands(32'sh0001_0000, 32'sh0002_0000,
			32'sh0003_0000, 32'sh0004_0000));
		send_command(MODE_CUBIC, 1'b0, operands(32'sd0, 32'sd0, COORD_MIN, COORD_MIN,
			COORD_MAX, COORD_MAX));
		// reflection overflows
		send_command(MODE_SMOOTH, 1'b1, operands(32'sd1, 32'sd1, 32'sd1, 32'sd1));
		send_command(MODE_CLOSE, 1'b1, random_operands());
		send_command(MODE_CUBIC, 1'b0, operands(32'sh0001_0000, 32'sh0002_0000,
			32'sh0003_0000, 32'sh0004_0000, 32'sh0005_0000, 32'sh0006_0000));
		// arc clears the cubic history
		send_command(MODE_ARC, 1'b1, random_operands());
		send_command(MODE_SMOOTH, 1'b0, operands(32'sh0001_0000, 32'sh0001_0000,
			32'sh0002_0000, 32'sh0002_0000));
		for (int m = 9; m < 16; m++)
			send_command(m[3:0], m[0], random_operands());
		send_command(MODE_MOVE, 1'b0, operands(COORD_MIN, COORD_MIN));
		send_command(MODE_MOVE, 1'b1, operands(COORD_MIN, COORD_MIN));
		send_command(MODE_LINE, 1'b0, operands(ones, ones, ones, ones, ones, ones));
		send_command(MODE_CLOSE, 1'b0, operands(ones, ones, ones, ones, ones, ones));
		send_command(MODE_QUAD, 1'b1, operands(COORD_MAX, COORD_MAX, COORD_MAX,
			COORD_MAX, COORD_MAX, COORD_MAX));
		send_command(MODE_HORIZ, 1'b0, operands(COORD_MAX));
		send_command(MODE_VERT, 1'b1, operands(COORD_MAX));
		send_command(MODE_SMOOTH, 1'b1, operands(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MIN));
	endtask

	// one subpath: move, a few segments, usually a close; some noise and broken paths
	task automatic send_random_path();
		int n;
		if ($urandom_range(9) == 0) begin
			send_command(4'($urandom_range(15)), random_rel(), random_operands());
			return;
		end
		if ($urandom_range(9) != 0)
			send_command(MODE_MOVE, random_rel(), random_operands());
		n = $urandom_range(1, 8);
		repeat (n) begin
			case ($urandom_range(19))
				0, 1, 2, 3: send_command(MODE_LINE, random_rel(), random_operands());
				4: send_command(MODE_HORIZ, random_rel(), random_operands());
				5: send_command(MODE_VERT, random_rel(), random_operands());
				6, 7, 8, 9: send_command(MODE_CUBIC, random_rel(), random_operands());
				10, 11, 12, 13: send_command(MODE_SMOOTH, random_rel(), random_operands());
				14, 15, 16: send_command(MODE_QUAD, random_rel(), random_operands());
				17: send_command(MODE_ARC, random_rel(), random_operands());
				18: send_command(MODE_CLOSE, random_rel(), random_operands());
				default: send_command(MODE_MOVE, random_rel(), random_operands());
			endcase
		end
		if ($urandom_range(3) != 0)
			send_command(MODE_CLOSE, random_rel(), random_operands());
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		sender_idle_pct = 6;
		receiver_stall_pct = 77;
		directed_paths();
		while (commands_sent < 300)
			send_random_path();
		drain_segments();

		sender_idle_pct = 77;
		receiver_stall_pct = 6;
		while (commands_sent < 590)
			send_random_path();
		drain_segments();

		// long output hold-off while commands keep coming
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		hold_left = HOLD_CYCLES;
		while (commands_sent < 845)
			send_random_path();
		drain_segments();
		repeat (10) @(posedge clk);

		if (sb.errors == 0)
			$display("[vector_path_command_resolver] OK");
		else
			$display("[vector_path_command_resolver] ERROR");
		$finish;
	end
endmodule
